// File: hw/rtl/fmc_pkg.sv
// Shared types and constants of the five-tuple first-match classifier.
// No dependencies; imported by the rule compare unit and the top level.
package fmc_pkg;

    localparam int MAX_RULES_DEF = 64;

    localparam logic [7:0] PROTO_CONTROL = 8'h01;
    localparam logic [7:0] PROTO_TCP     = 8'd6;
    localparam logic [7:0] PROTO_UDP     = 8'd17;

    localparam int IN_DATA_W  = 232;
    localparam int OUT_DATA_W = 24;
    localparam int CLASS_W    = 16;
    localparam int INDEX_W    = 6;

    typedef enum logic [2:0] {
        ST_MATCHED  = 3'd0,
        ST_CONTROL  = 3'd1,
        ST_NO_MATCH = 3'd2,
        ST_ADDED    = 3'd3,
        ST_FULL     = 3'd4
    } status_t;

    typedef enum logic {
        OP_ADD      = 1'b0,
        OP_CLASSIFY = 1'b1
    } op_t;

    // One stored rule.
    typedef struct packed {
        logic [7:0]  proto;
        logic [31:0] src_addr;
        logic [31:0] src_mask;
        logic [31:0] dst_addr;
        logic [31:0] dst_mask;
        logic [15:0] src_lo;
        logic [15:0] src_hi;
        logic [15:0] dst_lo;
        logic [15:0] dst_hi;
        logic [15:0] cls;
    } rule_t;

    // Header fields of the packet under classification.
    typedef struct packed {
        logic [7:0]  proto;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
    } pkt_t;

endpackage

// File: hw/rtl/fmc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module fmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: hw/rtl/fmc_rule_cmp.sv
// Rule compare unit: tests one stored rule against the packet header.
// Depends on fmc_pkg for the rule and packet types.
module fmc_rule_cmp
    import fmc_pkg::*;
(
    input  rule_t rule,
    input  pkt_t  pkt,
    output logic  hit
);

    logic proto_ok;
    logic src_ok;
    logic dst_ok;
    logic sport_ok;
    logic dport_ok;

    always_comb begin
        proto_ok = (rule.proto == pkt.proto);
        src_ok   = ((pkt.src_addr & rule.src_mask) == rule.src_addr);
        dst_ok   = ((pkt.dst_addr & rule.dst_mask) == rule.dst_addr);
        sport_ok = (pkt.src_port >= rule.src_lo) && (pkt.src_port <= rule.src_hi);
        dport_ok = (pkt.dst_port >= rule.dst_lo) && (pkt.dst_port <= rule.dst_hi);
        hit      = proto_ok && src_ok && dst_ok && sport_ok && dport_ok;
    end

endmodule

// File: hw/rtl/five_tuple_first_match_classifier.sv
// Five-tuple first-match classifier, top level.
// Each item gives one result transfer: an add writes one rule (a TCP rule pair for TCP), a control packet
// is answered without a walk, and classify walks the table to the first hit or, on a miss, to the end.
// Throughput: one item at a time; the walk reads one RAM entry per cycle through a single
// compare unit, and the next item is taken once the result sits in the output register.
// Reset: synchronous, active low; clears the rule count, so the table is empty.
module five_tuple_first_match_classifier
    import fmc_pkg::*;
#(
    parameter int MAX_RULES = MAX_RULES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata from bit 0: proto, src_addr, dst_addr, src_mask, dst_mask, src_port,
    // src_port_high, dst_port, dst_port_high, class_in, frag_offset, zero pad
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: op
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata from bit 0: class_out, rule_index, zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // tuser: status
    output logic [2:0]            m_axis_tuser
);

    localparam int IW = $clog2(MAX_RULES);
    localparam int CW = $clog2(MAX_RULES + 1);
    localparam logic [CW:0] MAX_W = (CW + 1)'(MAX_RULES);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_WRITE2 = 4'b0010,
        S_WALK   = 4'b0100,
        S_RESP   = 4'b1000
    } state_t;

    // Unpacked input fields.
    op_t         in_op;
    logic [7:0]  in_proto;
    logic [31:0] in_src_addr, in_dst_addr, in_src_mask, in_dst_mask;
    logic [15:0] in_src_port, in_src_port_high, in_dst_port, in_dst_port_high;
    logic [15:0] in_class;
    logic [12:0] in_frag;

    assign in_op            = op_t'(s_axis_tuser);
    assign in_proto         = s_axis_tdata[7:0];
    assign in_src_addr      = s_axis_tdata[39:8];
    assign in_dst_addr      = s_axis_tdata[71:40];
    assign in_src_mask      = s_axis_tdata[103:72];
    assign in_dst_mask      = s_axis_tdata[135:104];
    assign in_src_port      = s_axis_tdata[151:136];
    assign in_src_port_high = s_axis_tdata[167:152];
    assign in_dst_port      = s_axis_tdata[183:168];
    assign in_dst_port_high = s_axis_tdata[199:184];
    assign in_class         = s_axis_tdata[215:200];
    assign in_frag          = s_axis_tdata[228:216];

    state_t              state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       rd_idx_reg, rd_idx_next;
    logic                chk_valid_reg, chk_valid_next;
    logic [IW-1:0]       chk_idx_reg, chk_idx_next;
    logic [IW-1:0]       wr2_idx_reg, wr2_idx_next;
    rule_t               mirror_reg, mirror_next;
    pkt_t                pkt_reg, pkt_next;
    logic [CLASS_W-1:0]  res_class_reg, res_class_next;
    status_t             res_status_reg, res_status_next;
    logic [INDEX_W-1:0]  res_index_reg, res_index_next;
    logic                m_valid_reg, m_valid_next;
    logic [CLASS_W-1:0]  m_class_reg, m_class_next;
    status_t             m_status_reg, m_status_next;
    logic [INDEX_W-1:0]  m_index_reg, m_index_next;

    logic                accept;
    logic [CW:0]         need_total;
    logic                ports_used;
    logic                wr_en;
    logic [IW-1:0]       wr_addr;
    rule_t               wr_data;
    rule_t               in_rule;
    logic                rd_en;
    rule_t               rd_rule;
    logic                hit;
    logic [IW+INDEX_W-1:0] first_ext;
    logic [IW+INDEX_W-1:0] chk_ext;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - CLASS_W - INDEX_W){1'b0}}, m_index_reg, m_class_reg};
    assign m_axis_tuser  = m_status_reg;

    assign first_ext = {{INDEX_W{1'b0}}, count_reg[IW-1:0]};
    assign chk_ext   = {{INDEX_W{1'b0}}, chk_idx_reg};

    always_comb begin
        in_rule.proto    = in_proto;
        in_rule.src_addr = in_src_addr;
        in_rule.src_mask = in_src_mask;
        in_rule.dst_addr = in_dst_addr;
        in_rule.dst_mask = in_dst_mask;
        in_rule.src_lo   = in_src_port;
        in_rule.src_hi   = in_src_port_high;
        in_rule.dst_lo   = in_dst_port;
        in_rule.dst_hi   = in_dst_port_high;
        in_rule.cls      = in_class;
    end

    fmc_ram #(
        .WIDTH ($bits(rule_t)),
        .DEPTH (MAX_RULES)
    ) u_rule_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_idx_reg[IW-1:0]),
        .rd_data (rd_rule)
    );

    fmc_rule_cmp u_cmp (
        .rule (rd_rule),
        .pkt  (pkt_reg),
        .hit  (hit)
    );

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        rd_idx_next     = rd_idx_reg;
        chk_valid_next  = 1'b0;
        chk_idx_next    = chk_idx_reg;
        wr2_idx_next    = wr2_idx_reg;
        mirror_next     = mirror_reg;
        pkt_next        = pkt_reg;
        res_class_next  = res_class_reg;
        res_status_next = res_status_reg;
        res_index_next  = res_index_reg;
        m_valid_next    = m_valid_reg;
        m_class_next    = m_class_reg;
        m_status_next   = m_status_reg;
        m_index_next    = m_index_reg;
        wr_en           = 1'b0;
        wr_addr         = count_reg[IW-1:0];
        wr_data         = in_rule;
        rd_en           = 1'b0;
        need_total      = {1'b0, count_reg} + ((in_proto == PROTO_TCP) ? (CW + 1)'(2)
                                                                        : (CW + 1)'(1));
        ports_used      = ((in_proto == PROTO_TCP) || (in_proto == PROTO_UDP))
                          && (in_frag == 13'd0);

        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    res_class_next = '0;
                    res_index_next = '0;
                    if (in_op == OP_ADD) begin
                        if (need_total > MAX_W) begin
                            res_status_next = ST_FULL;
                            state_next      = S_RESP;
                        end else begin
                            wr_en           = 1'b1;
                            count_next      = need_total[CW-1:0];
                            res_status_next = ST_ADDED;
                            res_index_next  = first_ext[INDEX_W-1:0];
                            // The mirrored rule of a TCP pair goes in the next slot.
                            mirror_next.proto    = in_proto;
                            mirror_next.src_addr = in_dst_addr;
                            mirror_next.src_mask = in_dst_mask;
                            mirror_next.dst_addr = in_src_addr;
                            mirror_next.dst_mask = in_src_mask;
                            mirror_next.src_lo   = in_dst_port;
                            mirror_next.src_hi   = in_dst_port_high;
                            mirror_next.dst_lo   = in_src_port;
                            mirror_next.dst_hi   = in_src_port_high;
                            mirror_next.cls      = in_class;
                            wr2_idx_next = count_reg[IW-1:0] + IW'(1);
                            state_next   = (in_proto == PROTO_TCP) ? S_WRITE2 : S_RESP;
                        end
                    end else if (in_proto == PROTO_CONTROL) begin
                        res_status_next = ST_CONTROL;
                        state_next      = S_RESP;
                    end else begin
                        pkt_next.proto    = in_proto;
                        pkt_next.src_addr = in_src_addr;
                        pkt_next.dst_addr = in_dst_addr;
                        pkt_next.src_port = ports_used ? in_src_port : 16'd0;
                        pkt_next.dst_port = ports_used ? in_dst_port : 16'd0;
                        rd_idx_next       = '0;
                        state_next        = S_WALK;
                    end
                end
            end
            S_WRITE2: begin
                wr_en      = 1'b1;
                wr_addr    = wr2_idx_reg;
                wr_data    = mirror_reg;
                state_next = S_RESP;
            end
            S_WALK: begin
                // A read issued last cycle is checked while the next one is issued.
                if (chk_valid_reg && hit) begin
                    res_class_next  = rd_rule.cls;
                    res_status_next = ST_MATCHED;
                    res_index_next  = chk_ext[INDEX_W-1:0];
                    state_next      = S_RESP;
                end else if (rd_idx_reg < count_reg) begin
                    rd_en          = 1'b1;
                    chk_valid_next = 1'b1;
                    chk_idx_next   = rd_idx_reg[IW-1:0];
                    rd_idx_next    = rd_idx_reg + CW'(1);
                end else if (!chk_valid_reg) begin
                    res_class_next  = '0;
                    res_status_next = ST_NO_MATCH;
                    res_index_next  = '0;
                    state_next      = S_RESP;
                end
            end
            S_RESP: begin
                if (!m_valid_reg || m_axis_tready) begin
                    m_valid_next  = 1'b1;
                    m_class_next  = res_class_reg;
                    m_status_next = res_status_reg;
                    m_index_next  = res_index_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            chk_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            chk_valid_reg <= chk_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg     <= rd_idx_next;
        chk_idx_reg    <= chk_idx_next;
        wr2_idx_reg    <= wr2_idx_next;
        mirror_reg     <= mirror_next;
        pkt_reg        <= pkt_next;
        res_class_reg  <= res_class_next;
        res_status_reg <= res_status_next;
        res_index_reg  <= res_index_next;
        m_class_reg    <= m_class_next;
        m_status_reg   <= m_status_next;
        m_index_reg    <= m_index_next;
    end

endmodule
